@@ design/call_control_sequencer_top_assert.svh @@
// Assertion macros used by the call control sequencer checker
`ifndef CALL_CONTROL_SEQUENCER_TOP_ASSERT_SVH
`define CALL_CONTROL_SEQUENCER_TOP_ASSERT_SVH

// check a property outside of reset
`define CCS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every edge, reset included
`define CCS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ccs_pkg.sv @@
// Types and constants of the call control sequencer
package ccs_pkg;

   localparam int NUM_LINES = 8;
   localparam int LINE_W    = 3;
   localparam int DIGIT_W   = 4;
   localparam int COUNT_W   = 16;

   localparam logic [DIGIT_W-1:0] ALL_PHONES     = 4'd9;
   localparam logic [DIGIT_W-1:0] DIGIT_ZERO_KEY = 4'd10;

   localparam logic [1:0] DIAL_ROTARY = 2'd0;
   localparam logic [1:0] DIAL_TONE   = 2'd1;
   localparam logic [1:0] DIAL_NONE   = 2'd2;
   localparam logic [1:0] DIAL_HANGUP = 2'd3;

   localparam logic [COUNT_W-1:0] RING_HOLD_RESET = 16'd500;

   typedef enum logic [3:0] {
      ST_IDLE        = 4'd0,
      ST_TRUNK_ALERT = 4'd1,
      ST_EXT_ACC     = 4'd2,
      ST_LIFTED      = 4'd3,
      ST_SECOND      = 4'd4,
      ST_OUT_ROT     = 4'd5,
      ST_OUT_TONE    = 4'd6,
      ST_LOCAL_ALERT = 4'd7,
      ST_INT_ACC     = 4'd8
   } state_type;

   typedef enum logic [3:0] {
      CMD_RING_ALL     = 4'd0,
      CMD_DIAL_TONE    = 4'd1,
      CMD_ANSWER_EXT   = 4'd2,
      CMD_STOP_RING    = 4'd3,
      CMD_RELEASE      = 4'd4,
      CMD_OUT_ROT      = 4'd5,
      CMD_OUT_TONE     = 4'd6,
      CMD_ARM_SECOND   = 4'd7,
      CMD_RING_LINE    = 4'd8,
      CMD_CONNECT_INT  = 4'd9,
      CMD_FORWARD      = 4'd10,
      CMD_RELEASE_DROP = 4'd11
   } cmd_type;

   typedef struct packed {
      logic               req_type;
      logic               ring_sense_n;
      logic               line_present;
      logic [LINE_W-1:0]  line_number;
      logic               pickup;
      logic [1:0]         dial_result;
      logic [DIGIT_W-1:0] dialed_digit;
   } req_item_type;

   typedef struct packed {
      cmd_type            command;
      logic [LINE_W-1:0]  cmd_line;
      logic [DIGIT_W-1:0] cmd_digit;
      state_type          after_state;
   } rsp_item_type;

   typedef struct packed {
      logic               pending;
      logic [COUNT_W-1:0] count;
   } ring_state_type;

endpackage

@@ design/ccs_ring_detect.sv @@
// Ring indicator debounce and ring hold countdown, one tick step
module ccs_ring_detect
   import ccs_pkg::*;
(
   input  logic               ring_sense_n,
   input  logic [COUNT_W-1:0] ring_hold,
   input  ring_state_type     ring_cur,
   output ring_state_type     ring_next
);

   always_comb begin
      ring_next = ring_cur;
      if (!ring_sense_n && !ring_cur.pending) begin
         ring_next.pending = 1'b1;
      end else if (ring_sense_n && ring_cur.pending) begin
         ring_next.pending = 1'b0;
      end else if (!ring_sense_n && ring_cur.pending) begin
         ring_next.count   = ring_hold;
         ring_next.pending = 1'b0;
      end else if (ring_cur.count != '0) begin
         ring_next.count = ring_cur.count - COUNT_W'(1);
      end
   end

endmodule

@@ design/ccs_call_fsm.sv @@
// Call state machine: call state, ring detector and line/digit memory
module ccs_call_fsm
   import ccs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  req_item_type       req,
   input  logic [COUNT_W-1:0] ring_hold,
   output logic               emit,
   output rsp_item_type       rsp
);

   state_type          state_ff, state_in;
   ring_state_type     ring_ff, ring_in, ring_step;
   logic [LINE_W-1:0]  origin_ff, origin_in;
   logic [DIGIT_W-1:0] target_ff, target_in;
   cmd_type            cmd;
   logic [DIGIT_W-1:0] digit;
   logic               have_line;
   logic               is_tick;
   logic               state_ok;

   ccs_ring_detect u_ring_detect (
      .ring_sense_n (req.ring_sense_n),
      .ring_hold    (ring_hold),
      .ring_cur     (ring_ff),
      .ring_next    (ring_step)
   );

   assign have_line = req.line_present &&
                      ({1'b0, req.line_number} < (LINE_W+1)'(NUM_LINES));
   assign is_tick   = !req.req_type;
   assign state_ok  = (state_ff <= ST_INT_ACC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ring_ff   <= '0;
         origin_ff <= '0;
         target_ff <= '0;
      end else begin
         state_ff  <= state_in;
         ring_ff   <= ring_in;
         origin_ff <= origin_in;
         target_ff <= target_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ring_in   = ring_ff;
      origin_in = origin_ff;
      target_in = target_ff;
      emit      = 1'b0;
      cmd       = CMD_RELEASE;
      digit     = '0;
      if (fire) begin
         if (is_tick && state_ok) begin
            ring_in = ring_step;
         end
         case (state_ff)
            ST_IDLE: begin
               if (is_tick) begin
                  if (have_line) origin_in = req.line_number;
                  if (ring_in.count != '0) begin
                     emit     = 1'b1;
                     cmd      = CMD_RING_ALL;
                     digit    = ALL_PHONES;
                     state_in = ST_TRUNK_ALERT;
                  end else if (have_line) begin
                     emit     = 1'b1;
                     cmd      = CMD_DIAL_TONE;
                     state_in = ST_LIFTED;
                  end
               end
            end
            ST_TRUNK_ALERT: begin
               if (is_tick) begin
                  if (req.pickup) begin
                     ring_in.count = '0;
                     if (have_line) origin_in = req.line_number;
                     emit     = 1'b1;
                     cmd      = CMD_ANSWER_EXT;
                     state_in = ST_EXT_ACC;
                  end else if (ring_in.count == '0) begin
                     emit     = 1'b1;
                     cmd      = CMD_STOP_RING;
                     state_in = ST_IDLE;
                  end
               end
            end
            ST_EXT_ACC, ST_OUT_TONE, ST_INT_ACC: begin
               if (is_tick && !have_line) begin
                  emit     = 1'b1;
                  cmd      = CMD_RELEASE;
                  state_in = ST_IDLE;
               end
            end
            ST_LOCAL_ALERT: begin
               if (is_tick) begin
                  if (have_line) origin_in = req.line_number;
                  if (req.pickup) begin
                     emit     = 1'b1;
                     cmd      = CMD_CONNECT_INT;
                     digit    = target_ff;
                     state_in = ST_INT_ACC;
                  end else if (!have_line) begin
                     emit     = 1'b1;
                     cmd      = CMD_RELEASE;
                     state_in = ST_IDLE;
                  end
               end
            end
            ST_LIFTED: begin
               if (!is_tick) begin
                  emit = 1'b1;
                  if (req.dial_result == DIAL_ROTARY || req.dial_result == DIAL_TONE) begin
                     if (req.dialed_digit == DIGIT_ZERO_KEY) begin
                        if (req.dial_result == DIAL_ROTARY) begin
                           if (have_line) origin_in = req.line_number;
                           cmd      = CMD_OUT_ROT;
                           state_in = ST_OUT_ROT;
                        end else begin
                           cmd      = CMD_OUT_TONE;
                           state_in = ST_OUT_TONE;
                        end
                     end else begin
                        cmd      = CMD_ARM_SECOND;
                        state_in = ST_SECOND;
                     end
                  end else begin
                     cmd      = CMD_RELEASE;
                     state_in = ST_IDLE;
                  end
               end
            end
            ST_SECOND: begin
               if (!is_tick) begin
                  target_in = req.dialed_digit;
                  emit      = 1'b1;
                  cmd       = CMD_RING_LINE;
                  digit     = req.dialed_digit;
                  state_in  = ST_LOCAL_ALERT;
               end
            end
            ST_OUT_ROT: begin
               if (!is_tick) begin
                  if (req.dial_result == DIAL_ROTARY) begin
                     emit  = 1'b1;
                     cmd   = CMD_FORWARD;
                     digit = req.dialed_digit;
                  end else if (req.dial_result == DIAL_HANGUP) begin
                     emit     = 1'b1;
                     cmd      = CMD_RELEASE_DROP;
                     state_in = ST_IDLE;
                  end
               end
            end
            default: begin
               emit     = 1'b1;
               cmd      = CMD_RELEASE;
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      rsp.command     = cmd;
      rsp.cmd_line    = origin_in;
      rsp.cmd_digit   = digit;
      rsp.after_state = state_in;
   end

endmodule

@@ design/call_control_sequencer_top.sv @@
// Call control sequencer top level: request register, call FSM, response register
//
// Takes one request per clock cycle while no response is held waiting for
// rsp_ready. A request is registered on acceptance and evaluated against the
// call state once the response register is free or being read; its command
// (if any) is then registered and drives the response port. Throughput is set
// by the combinational call FSM between the request and response registers;
// the request side stalls only while a response is held waiting for rsp_ready.
// csr_write_data loads the ring hold time in ticks.
module call_control_sequencer_top
   import ccs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic               req_ring_sense_n,
   input  logic               req_line_present,
   input  logic [LINE_W-1:0]  req_line_number,
   input  logic               req_pickup,
   input  logic [1:0]         req_dial_result,
   input  logic [DIGIT_W-1:0] req_dialed_digit,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_command,
   output logic [LINE_W-1:0]  rsp_cmd_line,
   output logic [DIGIT_W-1:0] rsp_cmd_digit,
   output logic [3:0]         rsp_after_state,
   input  logic               csr_write_enable,
   input  logic [COUNT_W-1:0] csr_write_data
);

   logic               req_valid_ff, req_valid_in;
   req_item_type       req_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_ff, rsp_next;
   logic [COUNT_W-1:0] hold_ff;
   logic               fire;
   logic               emit;

   assign fire      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || fire;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_ready) begin
         req_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hold_ff      <= RING_HOLD_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            hold_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.req_type     <= req_type;
         req_ff.ring_sense_n <= req_ring_sense_n;
         req_ff.line_present <= req_line_present;
         req_ff.line_number  <= req_line_number;
         req_ff.pickup       <= req_pickup;
         req_ff.dial_result  <= req_dial_result;
         req_ff.dialed_digit <= req_dialed_digit;
      end
      if (fire && emit) begin
         rsp_ff <= rsp_next;
      end
   end

   ccs_call_fsm u_call_fsm (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .req       (req_ff),
      .ring_hold (hold_ff),
      .emit      (emit),
      .rsp       (rsp_next)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = rsp_ff.command;
   assign rsp_cmd_line    = rsp_ff.cmd_line;
   assign rsp_cmd_digit   = rsp_ff.cmd_digit;
   assign rsp_after_state = rsp_ff.after_state;

endmodule

@@ design/ccs_checker.sv @@
// Port-level checks for the call control sequencer, bound to the top level
`include "call_control_sequencer_top_assert.svh"

module ccs_checker
   import ccs_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [3:0]         rsp_command,
   input logic [LINE_W-1:0]  rsp_cmd_line,
   input logic [DIGIT_W-1:0] rsp_cmd_digit,
   input logic [3:0]         rsp_after_state
);

   `CCS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && req_ready, "response pending after reset")

   `CCS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_command, rsp_cmd_line, rsp_cmd_digit, rsp_after_state}), "stalled response changed")

   `CCS_ASSERT(a_stall_cause, clock, reset, !req_ready |-> rsp_valid && !rsp_ready, "request stalled without response backpressure")

   `CCS_ASSERT(a_release_idle, clock, reset, rsp_valid && (rsp_command == CMD_RELEASE || rsp_command == CMD_STOP_RING || rsp_command == CMD_RELEASE_DROP) |-> rsp_after_state == ST_IDLE, "release command without return to idle")

endmodule

bind call_control_sequencer_top ccs_checker u_ccs_checker (.*);
